[hdl/stok_pkg.sv]
package stok_pkg;

    localparam int OUT_W = 16;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       token_char;
        logic             token_first;
        logic             token_end;
        logic [OUT_W-1:0] token_line;
        logic [OUT_W-1:0] token_column;
        logic             token_truncated;
        logic             run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        LM_DEFAULT,
        LM_LINE,
        LM_BLOCK,
        LM_STRING
    } lex_mode_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SINGLE,
        OP_PAIR
    } op_kind_t;

    typedef enum logic [1:0] {
        EM_BUF,
        EM_OP_A,
        EM_OP_B
    } emit_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FL_RD,
        ST_FL_EM,
        ST_OP_A,
        ST_OP_B,
        ST_LAST
    } state_t;

    // held byte with the new byte as lookahead, new byte alone, final word flush
    typedef enum logic [1:0] {
        PASS_HELD,
        PASS_NEW,
        PASS_FINAL
    } pass_t;

    typedef struct packed {
        state_t st;
        pass_t  ps;
    } route_t;

    typedef struct packed {
        logic      accept;
        logic      eval;
        logic      eval_new;
        logic      commit;
        logic      commit_use_in;
        logic      commit_swallow;
        logic      commit_end;
        logic      rd_issue;
        logic      flush_done;
        logic      emit;
        emit_src_t emit_src;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic     held_valid;
        logic     len_zero;
        logic     ev_flush;
        op_kind_t ev_op;
        logic     ev_swallow;
        op_kind_t op_kind;
        logic     k_done;
        logic     advance;
    } ctrl_sts_t;

endpackage

[hdl/stok_ram.sv]
module stok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/stok_ctrl.sv]
module stok_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_end,
    input  stok_pkg::ctrl_sts_t sts,
    output stok_pkg::ctrl_cmd_t cmd
);

    import stok_pkg::*;

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;
    logic   end_reg, end_next;
    logic   swallow_reg, swallow_next;

    function automatic route_t route_after(pass_t p, logic e, logic sw);
        route_t r;
        r.st = ST_LAST;
        r.ps = p;
        case (p)
            PASS_HELD: begin
                if (e) begin
                    if (sw) begin
                        r.st = ST_FL_RD;
                        r.ps = PASS_FINAL;
                    end else begin
                        r.st = ST_EVAL;
                        r.ps = PASS_NEW;
                    end
                end
            end
            PASS_NEW: begin
                r.st = ST_FL_RD;
                r.ps = PASS_FINAL;
            end
            default: begin
                r.st = ST_LAST;
            end
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= PASS_HELD;
            end_reg     <= 1'b0;
            swallow_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            end_reg     <= end_next;
            swallow_reg <= swallow_next;
        end
    end

    always_comb begin
        route_t rt;
        logic   slow;
        state_next   = state_reg;
        pass_next    = pass_reg;
        end_next     = end_reg;
        swallow_next = swallow_reg;
        cmd          = '0;
        cmd.emit_src = EM_BUF;
        s_ready      = 1'b0;
        rt           = route_after(pass_reg, end_reg, swallow_reg);
        slow         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    end_next   = s_end;
                    if (sts.held_valid) begin
                        cmd.eval     = 1'b1;
                        pass_next    = PASS_HELD;
                        swallow_next = sts.ev_swallow;
                        slow = s_end || (sts.ev_flush && !sts.len_zero) ||
                               (sts.ev_op != OP_NONE);
                        rt = route_after(PASS_HELD, s_end, sts.ev_swallow);
                        if (!slow) begin
                            cmd.commit         = 1'b1;
                            cmd.commit_use_in  = 1'b1;
                            cmd.commit_swallow = sts.ev_swallow;
                        end else if (sts.ev_flush) begin
                            state_next = ST_FL_RD;
                        end else if (sts.ev_op != OP_NONE) begin
                            state_next = ST_OP_A;
                        end else begin
                            state_next = rt.st;
                            pass_next  = rt.ps;
                        end
                    end else begin
                        swallow_next = 1'b0;
                        if (s_end) begin
                            pass_next  = PASS_NEW;
                            state_next = ST_EVAL;
                        end else begin
                            cmd.commit        = 1'b1;
                            cmd.commit_use_in = 1'b1;
                        end
                    end
                end
            end
            ST_EVAL: begin
                cmd.eval     = 1'b1;
                cmd.eval_new = 1'b1;
                if (sts.ev_flush) begin
                    state_next = ST_FL_RD;
                end else if (sts.ev_op != OP_NONE) begin
                    state_next = ST_OP_A;
                end else begin
                    state_next = rt.st;
                    pass_next  = rt.ps;
                end
            end
            ST_FL_RD: begin
                if (sts.k_done) begin
                    cmd.flush_done = 1'b1;
                    if (pass_reg != PASS_FINAL && sts.op_kind != OP_NONE) begin
                        state_next = ST_OP_A;
                    end else begin
                        state_next = rt.st;
                        pass_next  = rt.ps;
                    end
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_FL_EM;
                end
            end
            ST_FL_EM: begin
                if (sts.advance) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EM_BUF;
                    state_next   = ST_FL_RD;
                end
            end
            ST_OP_A: begin
                if (sts.advance) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EM_OP_A;
                    if (sts.op_kind == OP_PAIR) begin
                        state_next = ST_OP_B;
                    end else begin
                        state_next = rt.st;
                        pass_next  = rt.ps;
                    end
                end
            end
            ST_OP_B: begin
                if (sts.advance) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EM_OP_B;
                    state_next   = rt.st;
                    pass_next    = rt.ps;
                end
            end
            ST_LAST: begin
                if (sts.advance) begin
                    cmd.finish         = 1'b1;
                    cmd.commit         = 1'b1;
                    cmd.commit_swallow = swallow_reg;
                    cmd.commit_end     = end_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.finish) |-> sts.advance)
        else $error("result staged while output stage is blocked");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_end && !sts.held_valid) |=> (state_reg == ST_IDLE))
        else $error("first byte of a run left the idle state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FL_EM) |-> ($past(cmd.rd_issue) || $past(state_reg) == ST_FL_EM))
        else $error("buffer character emitted without a read");

endmodule

[hdl/stok_dpath.sv]
module stok_dpath #(
    parameter int MAX_TOKEN_LEN = 32,
    parameter int POS_BITS      = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  stok_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stok_pkg::out_item_t m_data,
    input  stok_pkg::ctrl_cmd_t cmd,
    output stok_pkg::ctrl_sts_t sts
);

    import stok_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int AW    = $clog2(MAX_TOKEN_LEN);
    localparam int SUM_W = POS_BITS + 2;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LEN_W-1:0]    LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    function automatic logic is_split(logic [7:0] c);
        case (c)
            ":", ";", ",", ".", "{", "}", "(", ")", "[", "]", "*", "/", "+", "-",
            "&", "|", "=", "!", "<", ">", "'", "\"", "^", "?", "%", "\\", " ":
                is_split = 1'b1;
            default: is_split = 1'b0;
        endcase
    endfunction

    function automatic logic pairs_with(logic [7:0] a, logic [7:0] b);
        case (a)
            "=", "!", "<", ">": pairs_with = (b == "=");
            "-":                pairs_with = (b == "-") || (b == "=");
            "+":                pairs_with = (b == "+") || (b == "=");
            "*":                pairs_with = (b == "=") || (b == "/") || (b == "*");
            "/":                pairs_with = (b == "=") || (b == "*") || (b == "/");
            "|":                pairs_with = (b == "|");
            "&":                pairs_with = (b == "&");
            default:            pairs_with = 1'b0;
        endcase
    endfunction

    lex_mode_t           mode_reg, mode_next;
    logic [7:0]          held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [7:0]          in_char_reg, in_char_next;
    op_kind_t            op_kind_reg, op_kind_next;
    logic [7:0]          op_c_reg, op_c_next;
    logic [7:0]          op_n_reg, op_n_next;
    out_item_t           stg_reg, stg_next;
    logic                stg_valid_reg, stg_valid_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          ev_c, ev_nx, cc, rd_data;
    logic                ev_hn, hn, is_nl, is_cr, lc_end, sp_sw, close_cmt, dflt;
    lex_mode_t           m1, ev_mode;
    logic                ev_append, ev_flush, ev_swallow;
    op_kind_t            ev_op;
    logic [1:0]          col_step;
    logic [SUM_W-1:0]    col_sum;
    logic [POS_BITS-1:0] col_base, ev_col, ev_line;
    logic                len_full, out_free, advance, ram_we;
    out_item_t           res;

    always_comb begin
        ev_c  = cmd.eval_new ? in_char_reg : held_reg;
        ev_hn = !cmd.eval_new;
        ev_nx = cmd.eval_new ? 8'h00 : s_data.char_code;
        is_nl = (ev_c == CH_NL);
        is_cr = (ev_c == CH_CR);
        lc_end = is_nl && (mode_reg == LM_LINE);
        cc = (is_nl || is_cr) ? 8'(" ") : ev_c;
        sp_sw = !lc_end && (cc == " ") && ev_hn && (ev_nx == " ");
        hn = ev_hn && !sp_sw;
        m1 = mode_reg;
        close_cmt = 1'b0;
        if (mode_reg != LM_STRING && hn) begin
            if (cc == "/" && ev_nx == "/") begin
                m1 = LM_LINE;
            end else if (cc == "/" && ev_nx == "*") begin
                m1 = LM_BLOCK;
            end
            if (cc == "*" && ev_nx == "/") begin
                m1 = LM_DEFAULT;
                close_cmt = 1'b1;
            end
        end
        ev_mode    = m1;
        ev_append  = 1'b0;
        ev_flush   = 1'b0;
        ev_op      = OP_NONE;
        ev_swallow = sp_sw;
        dflt       = 1'b0;
        if (lc_end) begin
            ev_mode    = LM_DEFAULT;
            ev_swallow = 1'b0;
        end else if (close_cmt) begin
            ev_swallow = 1'b1;
        end else if (m1 == LM_LINE || m1 == LM_BLOCK) begin
            ev_swallow = sp_sw;
        end else if (cc == "\"") begin
            ev_mode   = (m1 == LM_STRING) ? LM_DEFAULT : LM_STRING;
            ev_append = 1'b1;
        end else if (m1 == LM_STRING) begin
            ev_append = 1'b1;
        end else begin
            dflt = 1'b1;
            if (!is_split(cc)) begin
                ev_append = 1'b1;
            end else begin
                ev_flush = 1'b1;
                if (cc != " ") begin
                    if (hn && pairs_with(cc, ev_nx)) begin
                        ev_op      = OP_PAIR;
                        ev_swallow = 1'b1;
                    end else begin
                        ev_op = OP_SINGLE;
                    end
                end
            end
        end
        col_step = 2'(is_cr) + 2'(sp_sw) + 2'(dflt);
        col_base = is_nl ? '0 : col_reg;
        col_sum  = SUM_W'(col_base) + SUM_W'(col_step);
        ev_col   = (col_sum > SUM_W'(POS_MAX)) ? POS_MAX : col_sum[POS_BITS-1:0];
        ev_line  = (is_nl && line_reg != POS_MAX) ? line_reg + 1'b1 : line_reg;
    end

    assign len_full = (len_reg >= LEN_MAX);
    assign ram_we   = cmd.eval && ev_append && !len_full;
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = !stg_valid_reg || out_free;

    stok_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TOKEN_LEN)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (cc),
        .re    (cmd.rd_issue),
        .raddr (k_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        res                 = '0;
        res.token_line      = OUT_W'(line_reg);
        res.token_column    = OUT_W'(col_reg);
        case (cmd.emit_src)
            EM_BUF: begin
                res.token_char      = rd_data;
                res.token_first     = (k_reg == '0);
                res.token_end       = (LEN_W'(k_reg + 1'b1) == len_reg);
                res.token_truncated = ovf_reg;
            end
            EM_OP_A: begin
                res.token_char  = op_c_reg;
                res.token_first = 1'b1;
                res.token_end   = (op_kind_reg != OP_PAIR);
            end
            EM_OP_B: begin
                res.token_char = op_n_reg;
                res.token_end  = 1'b1;
            end
            default: begin
                res.token_char = op_c_reg;
            end
        endcase
    end

    always_comb begin
        mode_next       = mode_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        in_char_next    = in_char_reg;
        op_kind_next    = op_kind_reg;
        op_c_next       = op_c_reg;
        op_n_next       = op_n_reg;
        stg_next        = stg_reg;
        stg_valid_next  = stg_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.accept) begin
            in_char_next = s_data.char_code;
        end
        if (cmd.eval) begin
            mode_next    = ev_mode;
            line_next    = ev_line;
            col_next     = ev_col;
            op_kind_next = ev_op;
            op_c_next    = cc;
            op_n_next    = ev_nx;
            if (ev_append) begin
                if (!len_full) begin
                    len_next = len_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (cmd.emit && cmd.emit_src == EM_BUF) begin
            k_next = k_reg + 1'b1;
        end
        if (cmd.flush_done) begin
            len_next = '0;
            ovf_next = 1'b0;
            k_next   = '0;
        end
        if (cmd.commit) begin
            if (cmd.commit_end) begin
                held_valid_next = 1'b0;
                held_next       = 8'h00;
                mode_next       = LM_DEFAULT;
                line_next       = POS_BITS'(1);
                col_next        = '0;
            end else if (held_valid_reg && cmd.commit_swallow) begin
                held_valid_next = 1'b0;
                held_next       = 8'h00;
            end else begin
                held_valid_next = 1'b1;
                held_next       = cmd.commit_use_in ? s_data.char_code : in_char_reg;
            end
        end

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if ((cmd.emit || cmd.finish) && stg_valid_reg) begin
            out_valid_next    = 1'b1;
            out_next          = stg_reg;
            out_next.run_last = cmd.finish;
        end
        if (cmd.emit) begin
            stg_next       = res;
            stg_valid_next = 1'b1;
        end
        if (cmd.finish) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= LM_DEFAULT;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            line_reg       <= POS_BITS'(1);
            col_reg        <= '0;
            k_reg          <= '0;
            op_kind_reg    <= OP_NONE;
            stg_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            k_reg          <= k_next;
            op_kind_reg    <= op_kind_next;
            stg_valid_reg  <= stg_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_char_reg <= in_char_next;
        op_c_reg    <= op_c_next;
        op_n_reg    <= op_n_next;
        stg_reg     <= stg_next;
        out_reg     <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.held_valid = held_valid_reg;
    assign sts.len_zero   = (len_reg == '0);
    assign sts.ev_flush   = ev_flush;
    assign sts.ev_op      = ev_op;
    assign sts.ev_swallow = ev_swallow;
    assign sts.op_kind    = op_kind_reg;
    assign sts.k_done     = (k_reg == len_reg);
    assign sts.advance    = advance;

    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("token length beyond buffer depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= len_reg)
        else $error("flush index past token length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.emit || cmd.finish) && stg_valid_reg) |-> out_free)
        else $error("output register overwritten before transfer");

endmodule

[hdl/source_text_tokenizer_top.sv]
// Streaming source text tokenizer. One byte per input transfer (end_of_text marks the last
// byte of a text); each token comes out one character per output transfer, carrying line,
// column, first/end and truncation marks, and run_last on the final result of an input.
// A byte that emits nothing is committed in the idle state. A byte that closes a word is
// taken, then each buffered word character is read and emitted (each token buffer read
// is registered and issued one character at a time), the word scan ends, each operator
// character is emitted and a last step closes the byte; end of text adds an evaluation
// of the final byte, unless the held byte swallowed it, and a second word scan. The next
// byte is accepted while the last result still waits in the output register.
module source_text_tokenizer_top #(
    parameter int MAX_TOKEN_LEN = 32,
    parameter int POS_BITS      = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stok_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stok_pkg::out_item_t m_data
);

    import stok_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    stok_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_end   (s_data.end_of_text),
        .sts     (sts),
        .cmd     (cmd)
    );

    stok_dpath #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POS_BITS      (POS_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
